### design/tefl_pkg.sv
// shared constants for the table entry free list
// no dependencies; used by tefl_clear, table_entry_free_list and the testbench
package tefl_pkg;

    // default table size
    localparam int TABLE_ENTRIES_DEF = 1024;

    // width of the index fields on the item ports
    localparam int FIELD_W = 10;

    // request codes carried in the mode field
    localparam logic MODE_ALLOC   = 1'b0;
    localparam logic MODE_RELEASE = 1'b1;

endpackage

### design/tefl_ram.sv
// generic single write port ram with one registered read port
// no dependencies
module tefl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### design/tefl_clear.sv
// post-reset sweep that writes the initial chain into the link memory
// uses tefl_pkg for the default table size
module tefl_clear #(
    parameter int TABLE_ENTRIES = tefl_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    output logic                             o_busy,
    output logic [$clog2(TABLE_ENTRIES)-1:0] o_wr_addr,
    output logic [$clog2(TABLE_ENTRIES):0]   o_wr_data
);

    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam logic [IW-1:0] LAST_ADDR = IW'(TABLE_ENTRIES - 1);

    logic          r_busy;
    logic [IW-1:0] r_addr;
    logic          n_busy;
    logic [IW-1:0] n_addr;
    logic          w_last;

    assign w_last = (r_addr == LAST_ADDR);

    always_comb begin
        n_busy = r_busy;
        n_addr = r_addr;
        if (r_busy) begin
            n_addr = r_addr + 1'b1;
            if (w_last) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_addr <= '0;
        end else begin
            r_busy <= n_busy;
            r_addr <= n_addr;
        end
    end

    // entry i links to i+1; the last entry carries the null mark
    assign o_busy    = r_busy;
    assign o_wr_addr = r_addr;
    assign o_wr_data = w_last ? {1'b1, {IW{1'b0}}} : {1'b0, IW'(r_addr + 1'b1)};

endmodule

### design/table_entry_free_list.sv
// Free list allocator for a table of TABLE_ENTRIES entries. After reset the
// block writes the initial chain into its link memory, one entry a cycle, and
// holds o_ready low meanwhile. Then it takes one item at a time: it reads the
// head's link from the link memory and waits in S_EXEC for a free output
// register; an allocate then moves the head to that link, and a release of an
// index inside the table writes two links through the single write port, the
// second in S_LINK. An allocate that would hand out the last free entry fails
// with o_failed set. The result sits in an output register, so a new item is
// taken while it waits. Top level; uses tefl_pkg, tefl_ram and tefl_clear
module table_entry_free_list #(
    parameter int TABLE_ENTRIES = tefl_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic                         i_mode,
    input  logic [tefl_pkg::FIELD_W-1:0] i_release_index,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [tefl_pkg::FIELD_W-1:0] o_granted_index,
    output logic                         o_failed
);

    localparam int FW = tefl_pkg::FIELD_W;
    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam int LW = IW + 1;
    localparam int CW = ((IW > FW) ? IW : FW) + 1;
    localparam logic [CW-1:0] ENTRIES_C = CW'(TABLE_ENTRIES);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_LINK
    } t_state;

    t_state          r_state;
    logic [IW-1:0]   r_head;
    logic            r_mode;
    logic [FW-1:0]   r_rel;
    logic            r_o_valid;
    logic [FW-1:0]   r_o_granted;
    logic            r_o_failed;

    logic            w_clr_busy;
    logic [IW-1:0]   w_clr_addr;
    logic [LW-1:0]   w_clr_data;
    logic            w_in_acc;
    logic            w_slot_free;
    logic            w_finish;
    logic [LW-1:0]   w_rd_data;
    logic            w_link_null;
    logic [IW-1:0]   w_link_idx;
    logic [IW+FW-1:0] w_head_pad;
    logic [FW+IW-1:0] w_rel_pad;
    logic [IW-1:0]   w_rel_addr;
    logic [CW-1:0]   w_rel_ext;
    logic            w_rel_ok;
    logic            w_wr_en;
    logic [IW-1:0]   w_wr_addr;
    logic [LW-1:0]   w_wr_data;

    tefl_clear #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_clear (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .o_busy    (w_clr_busy),
        .o_wr_addr (w_clr_addr),
        .o_wr_data (w_clr_data)
    );

    tefl_ram #(
        .WIDTH(LW),
        .DEPTH(TABLE_ENTRIES)
    ) u_links (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_in_acc),
        .i_rd_addr (r_head),
        .o_rd_data (w_rd_data)
    );

    assign o_ready     = (r_state == S_IDLE) && !w_clr_busy;
    assign w_in_acc    = i_valid && o_ready;
    assign w_slot_free = !r_o_valid || i_ready;
    assign w_finish    = (r_state == S_EXEC) && w_slot_free;

    assign w_link_null = w_rd_data[IW];
    assign w_link_idx  = w_rd_data[IW-1:0];

    assign w_head_pad = {{FW{1'b0}}, r_head};
    assign w_rel_pad  = {{IW{1'b0}}, r_rel};
    assign w_rel_addr = w_rel_pad[IW-1:0];
    assign w_rel_ext  = CW'(r_rel);
    assign w_rel_ok   = (w_rel_ext < ENTRIES_C);

    // release: first the new entry takes over the head's link, then the head
    // points at it; this order makes a release of the head link to itself
    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = w_rel_addr;
        w_wr_data = w_rd_data;
        if (w_clr_busy) begin
            w_wr_en   = 1'b1;
            w_wr_addr = w_clr_addr;
            w_wr_data = w_clr_data;
        end else if (w_finish && (r_mode == tefl_pkg::MODE_RELEASE) && w_rel_ok) begin
            w_wr_en   = 1'b1;
            w_wr_addr = w_rel_addr;
            w_wr_data = w_rd_data;
        end else if (r_state == S_LINK) begin
            w_wr_en   = 1'b1;
            w_wr_addr = r_head;
            w_wr_data = {1'b0, w_rel_addr};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_head    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (r_o_valid && i_ready && !w_finish) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (w_slot_free) begin
                        r_o_valid <= 1'b1;
                        if (r_mode == tefl_pkg::MODE_ALLOC) begin
                            r_state <= S_IDLE;
                            if (!w_link_null) begin
                                r_head <= w_link_idx;
                            end
                        end else if (w_rel_ok) begin
                            r_state <= S_LINK;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_LINK: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // item and result payload
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_mode <= i_mode;
            r_rel  <= i_release_index;
        end
        if (w_finish) begin
            if (r_mode == tefl_pkg::MODE_ALLOC) begin
                r_o_granted <= w_link_null ? '0 : w_head_pad[FW-1:0];
                r_o_failed  <= w_link_null;
            end else begin
                r_o_granted <= r_rel;
                r_o_failed  <= 1'b0;
            end
        end
    end

    assign o_valid         = r_o_valid;
    assign o_granted_index = r_o_granted;
    assign o_failed        = r_o_failed;

`ifndef SYNTHESIS
    a_head_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CW'(r_head) < ENTRIES_C)
        else $error("free list head outside the table");

    a_no_work_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clr_busy |-> (r_state == S_IDLE) && !r_o_valid)
        else $error("item in flight while the link memory is swept");

    a_result_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_o_valid) |-> $past(r_state == S_EXEC))
        else $error("result produced outside the execute step");

    a_alloc_moves_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_finish && (r_mode == tefl_pkg::MODE_ALLOC) && !w_link_null)
        |=> r_head == $past(w_link_idx))
        else $error("head not advanced after a granted item");
`endif

endmodule

### dv/tb.sv
`timescale 1ns / 100ps
// testbench for table_entry_free_list: directed and random allocate/release items,
// each result checked against an in-bench model of the free list; needs tefl_pkg and the rtl
module tb;

    localparam int ENTRIES     = tefl_pkg::TABLE_ENTRIES_DEF;
    localparam int CLK_PERIOD  = 12;
    localparam int IDLE_PCT    = 11;
    localparam int STALL_LIMIT = 5000;
    localparam int TAIL_CYCLES = 20;

    typedef logic [tefl_pkg::FIELD_W-1:0] t_idx;
    typedef struct packed {
        t_idx granted;
        logic failed;
    } t_grant;

    logic i_clk           = 1'b0;
    logic i_rst_n         = 1'b0;
    logic i_valid         = 1'b0;
    logic i_mode          = tefl_pkg::MODE_ALLOC;
    t_idx i_release_index = '0;
    logic i_ready         = 1'b0;
    logic o_ready;
    logic o_valid;
    logic o_failed;
    t_idx o_granted_index;

    // free list as the block should hold it
    int     free_head;
    t_idx   link_idx [ENTRIES];
    logic   link_nul [ENTRIES];
    t_grant pending_grants[$];
    t_idx   held_entries[$];
    int     alloc_fails  = 0;
    int     errors       = 0;
    int     stall_cycles = 0;
    logic   calm         = 1'b0;

    table_entry_free_list dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_mode          (i_mode),
        .i_release_index (i_release_index),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_granted_index (o_granted_index),
        .o_failed        (o_failed)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic void reset_free_list();
        free_head = 0;
        for (int i = 0; i < ENTRIES; i++) begin
            link_idx[i] = t_idx'(i + 1);
            link_nul[i] = 1'b0;
        end
        link_idx[ENTRIES-1] = '0;
        link_nul[ENTRIES-1] = 1'b1;
    endfunction

    // one accepted item: update the list and queue the result it must give
    function automatic void apply_request(input logic mode, input t_idx rel);
        t_grant res;
        int     head;
        head        = free_head;
        res.granted = rel;
        res.failed  = 1'b0;
        if (mode == tefl_pkg::MODE_ALLOC) begin
            // the last free entry is never handed out
            if (head >= ENTRIES || link_nul[head]) begin
                res.granted = '0;
                res.failed  = 1'b1;
                alloc_fails++;
            end else begin
                res.granted = t_idx'(head);
                held_entries.push_back(res.granted);
                free_head = link_idx[head];
            end
        end else if (rel < ENTRIES && head < ENTRIES) begin
            // released entry goes in right after the head
            link_idx[rel]  = link_idx[head];
            link_nul[rel]  = link_nul[head];
            link_idx[head] = rel;
            link_nul[head] = 1'b0;
        end
        pending_grants.push_back(res);
    endfunction

    task automatic report_mismatch(input string what, input int want, input int got);
        $display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, want, got);
        errors++;
    endtask

    task automatic send_item(input logic mode, input t_idx rel);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_mode          <= mode;
        i_release_index <= rel;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        apply_request(mode, rel);
    endtask

    task automatic release_entry(input t_idx e);
        int hits[$];
        hits = held_entries.find_first_index(x) with (x == e);
        if (hits.size() != 0) held_entries.delete(hits[0]);
        send_item(tefl_pkg::MODE_RELEASE, e);
    endtask

    task automatic release_held();
        if (held_entries.size() == 0) begin
            send_item(tefl_pkg::MODE_ALLOC, t_idx'($urandom));
        end else begin
            release_entry(held_entries[$urandom_range(held_entries.size() - 1)]);
        end
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_grants.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed();
        send_item(tefl_pkg::MODE_ALLOC, '1);          // index field is don't-care on allocate
        send_item(tefl_pkg::MODE_ALLOC, '0);
        send_item(tefl_pkg::MODE_ALLOC, 10'h2aa);
        release_entry(10'd1);
        release_entry(10'd0);
        send_item(tefl_pkg::MODE_ALLOC, 10'h155);
        send_item(tefl_pkg::MODE_ALLOC, '1);
        release_entry(10'd2);
        repeat (3) send_item(tefl_pkg::MODE_ALLOC, t_idx'($urandom));
        wait_drained();
    endtask

    // mostly allocations until the list runs dry and allocations fail
    task automatic test_fill_to_empty();
        int n;
        n    = 0;
        calm = 1'b1;
        while (alloc_fails == 0 && n < 2000) begin
            if (n == 300) calm = 1'b0;
            if ($urandom_range(99) < 90) send_item(tefl_pkg::MODE_ALLOC, t_idx'($urandom));
            else release_held();
            n++;
        end
        calm = 1'b0;
        repeat (3) send_item(tefl_pkg::MODE_ALLOC, t_idx'($urandom));
        wait_drained();
    endtask

    task automatic test_drain_mixed();
        int roll;
        repeat (170) begin
            roll = $urandom_range(99);
            if (roll < 30) send_item(tefl_pkg::MODE_ALLOC, t_idx'($urandom));
            else if (roll < 95) release_held();
            else send_item(tefl_pkg::MODE_RELEASE, t_idx'($urandom));  // may hit a free entry
        end
        wait_drained();
    endtask

    // releases of entries already on the list; the head release leaves it looping
    task automatic test_free_entry_release();
        if (!link_nul[free_head]) send_item(tefl_pkg::MODE_RELEASE, link_idx[free_head]);
        send_item(tefl_pkg::MODE_RELEASE, '1);
        send_item(tefl_pkg::MODE_RELEASE, t_idx'(free_head));
        repeat (4) send_item(tefl_pkg::MODE_ALLOC, t_idx'($urandom));
    endtask

    always @(posedge i_clk) begin
        i_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge i_clk) begin
        t_grant want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_grants.size() == 0) begin
                report_mismatch("result with no item pending, granted_index", -1,
                                o_granted_index);
            end else begin
                want = pending_grants.pop_front();
                if (o_granted_index !== want.granted)
                    report_mismatch("granted_index", want.granted, o_granted_index);
                if (o_failed !== want.failed)
                    report_mismatch("failed", want.failed, o_failed);
            end
        end
    end

    // covers the clearing pass after reset as well as a hung handshake
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        reset_free_list();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_fill_to_empty();
        test_drain_mixed();
        test_free_entry_release();
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

### sim.f
design/tefl_pkg.sv
design/tefl_ram.sv
design/tefl_clear.sv
design/table_entry_free_list.sv
dv/tb.sv
